// ===== hdl/tpg_pkg.sv =====
// package: shared types and constants for the test pattern pixel generator
package tpg_pkg;

  // pattern modes
  localparam logic [1:0] MODE_DIAG    = 2'd0;
  localparam logic [1:0] MODE_RADIAL  = 2'd1;
  localparam logic [1:0] MODE_STRIPES = 2'd2;
  localparam logic [1:0] MODE_FLAT    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int VAL_W   = 16;

  localparam logic [DIM_W-1:0] MAX_DIM       = 13'd4096;
  localparam int               STRIPE_SHIFT  = 5;      // stripes 32 rows tall
  localparam logic [VAL_W-1:0] STRIPE_LO_VAL = 16'd15000;
  localparam logic [VAL_W-1:0] STRIPE_HI_VAL = 16'd50000;
  localparam logic [VAL_W-1:0] FLAT_VAL      = 16'd32768;

  // square root of (a << 32), a is a sum of two 13-bit squares
  localparam int SQ_W       = 2 * DIM_W;          // one square
  localparam int RAD_IN_W   = SQ_W + 1;           // sum of squares
  localparam int ROOT_STEPS = (RAD_IN_W + 32 + 1) / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int RAD_W      = 2 * ROOT_STEPS;     // scaled radicand
  localparam int REM_W      = ROOT_W + 1;

  // divider: quotient always fits 16 bits
  localparam int DIV_STEPS = VAL_W;
  localparam int NUM_W     = ROOT_W + VAL_W;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [VAL_W-1:0]   frame_index;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] pixel_value;
    logic             end_of_frame;
    logic             out_of_range;
  } out_item_t;

  // per-item sideband that rides along the cell chains
  typedef struct packed {
    logic             valid;
    logic [1:0]       mode;
    logic [VAL_W-1:0] frame_index;
    logic             oor;
    logic             eof;
    logic             stripe;
    logic [DIM_W-1:0] sum_xy;
    logic [DIM_W:0]   sum_wh;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  bits;
  } root_lane_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] dsh;
    logic [VAL_W-1:0] q;
  } div_lane_t;

endpackage

// ===== hdl/tpg_root_cell.sv =====
// module: one digit step of the two square-root lanes, with sideband
module tpg_root_cell (
  input  logic               clk,
  input  logic               rst,
  input  tpg_pkg::side_t      side_in,
  input  tpg_pkg::root_lane_t rd_in,
  input  tpg_pkg::root_lane_t rm_in,
  output tpg_pkg::side_t      side_out,
  output tpg_pkg::root_lane_t rd_out,
  output tpg_pkg::root_lane_t rm_out
);
  import tpg_pkg::*;

  function automatic root_lane_t root_step(root_lane_t s);
    logic [ROOT_W+2:0] sh;
    logic [ROOT_W+2:0] trial;
    root_lane_t        r;
    begin
      sh    = {s.rem, s.bits[RAD_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      if (sh >= trial) begin
        r.rem  = REM_W'(sh - trial);
        r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = REM_W'(sh);
        r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      r.bits = {s.bits[RAD_W-3:0], 2'b00};
      root_step = r;
    end
  endfunction

  always_ff @(posedge clk) begin
    rd_out <= root_step(rd_in);
    rm_out <= root_step(rm_in);
    if (rst) begin
      side_out <= '0;
    end else begin
      side_out <= side_in;
    end
  end

endmodule

// ===== hdl/tpg_div_cell.sv =====
// module: one restoring-division step, with sideband
module tpg_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  tpg_pkg::side_t     side_in,
  input  tpg_pkg::div_lane_t div_in,
  output tpg_pkg::side_t     side_out,
  output tpg_pkg::div_lane_t div_out
);
  import tpg_pkg::*;

  div_lane_t nxt;

  always_comb begin
    nxt.dsh = {1'b0, div_in.dsh[NUM_W-1:1]};
    if (div_in.rem >= div_in.dsh) begin
      nxt.rem = div_in.rem - div_in.dsh;
      nxt.q   = {div_in.q[VAL_W-2:0], 1'b1};
    end else begin
      nxt.rem = div_in.rem;
      nxt.q   = {div_in.q[VAL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    div_out <= nxt;
    if (rst) begin
      side_out <= '0;
    end else begin
      side_out <= side_in;
    end
  end

endmodule

// ===== hdl/test_pattern_pixel_generator_unit.sv =====
// module: top level of the test pattern pixel generator
//
// Takes one pixel request per clock (start while busy is low; busy never rises)
// and returns its pattern value as a one-cycle done strobe with the result
// item; the receiver cannot stall, so every accepted item comes out exactly
// once in order. The pipeline holds two setup stages (offsets, then squares),
// a row of 30 square-root cells that work the pixel radius and the frame
// radius side by side one digit a cell, a row of 16 divider cells yielding
// one quotient bit each, and an output register. Configuration writes are
// always ready and take effect for items started after the write; change
// them only while no item is in flight.
module test_pattern_pixel_generator_unit (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               start,
  output logic               busy,
  input  tpg_pkg::in_item_t  request,
  // result side
  output logic               done,
  output tpg_pkg::out_item_t result,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import tpg_pkg::*;

  // configuration registers
  logic [1:0]       pattern_mode;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= MODE_DIAG;
      frame_width  <= 13'd2048;
      frame_height <= 13'd2048;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:   pattern_mode <= cfg_data[1:0];
        REG_WIDTH:  frame_width  <= cfg_data;
        REG_HEIGHT: frame_height <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------- stage a: bounds, offsets from center ----------------
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0] x2, y2;
  side_t            side_a_next, side_a;
  logic [DIM_W-1:0] dx_a_next, dy_a_next, dx_a, dy_a;
  logic [DIM_W-1:0] w_a, h_a;

  assign w_eff = (frame_width  > MAX_DIM) ? MAX_DIM : frame_width;
  assign h_eff = (frame_height > MAX_DIM) ? MAX_DIM : frame_height;
  assign x2    = {request.pixel_x, 1'b0};
  assign y2    = {request.pixel_y, 1'b0};

  always_comb begin
    side_a_next.valid       = start && !busy;
    side_a_next.mode        = pattern_mode;
    side_a_next.frame_index = request.frame_index;
    side_a_next.oor         = ({1'b0, request.pixel_x} >= w_eff)
                           || ({1'b0, request.pixel_y} >= h_eff);
    side_a_next.eof         = ({1'b0, request.pixel_x} == w_eff - 13'd1)
                           && ({1'b0, request.pixel_y} == h_eff - 13'd1);
    side_a_next.stripe      = request.pixel_y[STRIPE_SHIFT];
    side_a_next.sum_xy      = {1'b0, request.pixel_x} + {1'b0, request.pixel_y};
    side_a_next.sum_wh      = {1'b0, w_eff} + {1'b0, h_eff};
    // absolute distance of doubled coordinate from frame size
    dx_a_next = (x2 >= w_eff) ? x2 - w_eff : w_eff - x2;
    dy_a_next = (y2 >= h_eff) ? y2 - h_eff : h_eff - y2;
  end

  always_ff @(posedge clk) begin
    dx_a <= dx_a_next;
    dy_a <= dy_a_next;
    w_a  <= w_eff;
    h_a  <= h_eff;
    if (rst) begin
      side_a <= '0;
    end else begin
      side_a <= side_a_next;
    end
  end

  // ---------------- stage b: squares ----------------
  side_t           side_b;
  logic [SQ_W-1:0] dx2_b, dy2_b, w2_b, h2_b;

  always_ff @(posedge clk) begin
    dx2_b <= dx_a * dx_a;
    dy2_b <= dy_a * dy_a;
    w2_b  <= w_a * w_a;
    h2_b  <= h_a * h_a;
    if (rst) begin
      side_b <= '0;
    end else begin
      side_b <= side_a;
    end
  end

  // ---------------- square-root cell row ----------------
  side_t      root_side [0:ROOT_STEPS];
  root_lane_t root_rd   [0:ROOT_STEPS];
  root_lane_t root_rm   [0:ROOT_STEPS];

  logic [RAD_IN_W-1:0] rad_d, rad_m;

  assign rad_d = {1'b0, dx2_b} + {1'b0, dy2_b};
  assign rad_m = {1'b0, w2_b} + {1'b0, h2_b};

  // radicand scaled by 2^32, fed into the row msb first
  always_comb begin
    root_side[0]    = side_b;
    root_rd[0].rem  = '0;
    root_rd[0].root = '0;
    root_rd[0].bits = RAD_W'({rad_d, 32'd0});
    root_rm[0].rem  = '0;
    root_rm[0].root = '0;
    root_rm[0].bits = RAD_W'({rad_m, 32'd0});
  end

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
    tpg_root_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (root_side[i]),
      .rd_in    (root_rd[i]),
      .rm_in    (root_rm[i]),
      .side_out (root_side[i+1]),
      .rd_out   (root_rd[i+1]),
      .rm_out   (root_rm[i+1])
    );
  end

  // ---------------- divider cell row ----------------
  side_t     div_side [0:DIV_STEPS];
  div_lane_t div_lane [0:DIV_STEPS];

  logic [NUM_W-1:0] num_rad, num_diag;
  logic [NUM_W-1:0] den_rad, den_diag;

  // times 65535 as a shift and subtract
  assign num_rad  = ({root_rd[ROOT_STEPS].root, 16'd0})
                  - NUM_W'(root_rd[ROOT_STEPS].root);
  assign num_diag = NUM_W'({root_side[ROOT_STEPS].sum_xy, 16'd0})
                  - NUM_W'(root_side[ROOT_STEPS].sum_xy);
  // divisor aligned with the top quotient bit
  assign den_rad  = NUM_W'({root_rm[ROOT_STEPS].root, 15'd0});
  assign den_diag = NUM_W'({root_side[ROOT_STEPS].sum_wh, 15'd0});

  always_comb begin
    div_side[0]   = root_side[ROOT_STEPS];
    div_lane[0].q = '0;
    if (root_side[ROOT_STEPS].mode == MODE_RADIAL) begin
      div_lane[0].rem = num_rad;
      div_lane[0].dsh = den_rad;
    end else begin
      div_lane[0].rem = num_diag;
      div_lane[0].dsh = den_diag;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    tpg_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (div_side[j]),
      .div_in   (div_lane[j]),
      .side_out (div_side[j+1]),
      .div_out  (div_lane[j+1])
    );
  end

  // ---------------- output stage ----------------
  side_t            side_z;
  logic [VAL_W-1:0] base_val, frame_ofs;
  out_item_t        result_next;

  assign side_z = div_side[DIV_STEPS];

  // frame_index * 50 modulo 2^16
  assign frame_ofs = {side_z.frame_index[10:0], 5'd0}
                   + {side_z.frame_index[11:0], 4'd0}
                   + {side_z.frame_index[14:0], 1'b0};

  always_comb begin
    case (side_z.mode)
      MODE_DIAG:    base_val = div_lane[DIV_STEPS].q;
      MODE_RADIAL:  base_val = div_lane[DIV_STEPS].q;
      MODE_STRIPES: base_val = side_z.stripe ? STRIPE_HI_VAL : STRIPE_LO_VAL;
      MODE_FLAT:    base_val = FLAT_VAL;
      default:      base_val = FLAT_VAL;
    endcase
    if (side_z.oor) begin
      result_next.pixel_value  = '0;
      result_next.end_of_frame = 1'b0;
      result_next.out_of_range = 1'b1;
    end else begin
      result_next.pixel_value  = base_val + frame_ofs;
      result_next.end_of_frame = side_z.eof;
      result_next.out_of_range = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_z.valid;
    end
  end

endmodule

// ===== sim/tb_test_pattern_pixel_generator_unit.sv =====
// testbench for the test pattern pixel generator: directed and random items vs a predictor
module tb_test_pattern_pixel_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tpg_pkg::*;

  localparam int LATENCY = 49;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t request = '0;
  logic done;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;

  // predictor copy of the registers
  logic [1:0] cur_mode = MODE_DIAG;
  logic [12:0] cur_width = 13'd2048;
  logic [12:0] cur_height = 13'd2048;

  out_item_t expected_pixels[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit idle_enable = 1'b1;

  test_pattern_pixel_generator_unit i_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .request(request),
    .done(done), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // cycle counter with a hard timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // floor(sqrt(a * 2^32)), digit by digit
  function automatic logic [63:0] scaled_root(input logic [63:0] a);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] trial;
    logic [71:0] radicand;
    root = 0;
    rem = 0;
    radicand = {a[35:0], 32'd0};
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | radicand[2*i +: 2];
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic out_item_t pattern_pixel(input in_item_t req);
    out_item_t o;
    logic [63:0] x, y, w, h, v, dx, dy, rd, rm;
    x = req.pixel_x;
    y = req.pixel_y;
    w = (cur_width > MAX_DIM) ? MAX_DIM : cur_width;
    h = (cur_height > MAX_DIM) ? MAX_DIM : cur_height;
    o = '0;
    if (x >= w || y >= h) begin
      o.out_of_range = 1'b1;
      return o;
    end
    case (cur_mode)
      MODE_DIAG: v = ((x + y) * 65535) / (w + h);
      MODE_RADIAL: begin
        dx = (2 * x >= w) ? 2 * x - w : w - 2 * x;
        dy = (2 * y >= h) ? 2 * y - h : h - 2 * y;
        rd = scaled_root(dx * dx + dy * dy);
        rm = scaled_root(w * w + h * h);
        v = (rm != 0) ? (65535 * rd) / rm : 0;
        if (v > 65535) v = 65535;
      end
      MODE_STRIPES: v = y[STRIPE_SHIFT] ? STRIPE_HI_VAL : STRIPE_LO_VAL;
      default: v = FLAT_VAL;
    endcase
    o.pixel_value = 16'(v + req.frame_index * 50);
    o.end_of_frame = (x == w - 1 && y == h - 1);
    return o;
  endfunction

  // result checker: every strobe must match the oldest expected pixel
  always @(posedge clk) begin
    out_item_t exp_pix;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no expected pixel waiting");
        fail_count++;
      end else begin
        exp_pix = expected_pixels.pop_front();
        if (result.pixel_value !== exp_pix.pixel_value) begin
          $error("pixel_value exp %0d got %0d", exp_pix.pixel_value, result.pixel_value);
          fail_count++;
        end
        if (result.end_of_frame !== exp_pix.end_of_frame) begin
          $error("end_of_frame exp %0b got %0b", exp_pix.end_of_frame, result.end_of_frame);
          fail_count++;
        end
        if (result.out_of_range !== exp_pix.out_of_range) begin
          $error("out_of_range exp %0b got %0b", exp_pix.out_of_range, result.out_of_range);
          fail_count++;
        end
      end
    end
  end

  // random idle burst before an item, sometimes
  task automatic maybe_idle();
    int gap;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(posedge clk);
    end
  endtask

  // send one pixel request; start stays high across back-to-back items
  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                            input logic [15:0] fidx);
    in_item_t req;
    maybe_idle();
    req.pixel_x = px;
    req.pixel_y = py;
    req.frame_index = fidx;
    start <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_pixels = {expected_pixels, pattern_pixel(req)};
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE: cur_mode = data[1:0];
      REG_WIDTH: cur_width = data;
      REG_HEIGHT: cur_height = data;
      default: ;
    endcase
  endtask

  task automatic setup_frame(input logic [1:0] mode, input logic [12:0] w,
                             input logic [12:0] h);
    drain();
    write_reg(REG_MODE, {11'd0, mode});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // directed: corners, every mode, out of range, zero and oversize frames
  task automatic test_directed();
    // reset settings first, corner of a 2048 frame
    send_pixel(12'd0, 12'd0, 16'd0);
    send_pixel(12'd2047, 12'd2047, 16'hFFFF);
    send_pixel(12'd2048, 12'd0, 16'd7);
    for (int m = 0; m < 4; m++) begin
      setup_frame(m[1:0], 13'd4096, 13'd4096);
      send_pixel(12'd0, 12'd0, 16'd0);
      send_pixel(12'd4095, 12'd4095, 16'hFFFF);
      send_pixel(12'd2048, 12'd2048, 16'd1311);
      send_pixel(12'd31, 12'd32, 16'd1);
    end
    // oversize registers saturate; zero size makes everything out of range
    setup_frame(MODE_RADIAL, 13'h1FFF, 13'h1FFF);
    send_pixel(12'd4095, 12'd0, 16'd3);
    send_pixel(12'd4095, 12'd4095, 16'd9);
    setup_frame(MODE_DIAG, 13'd0, 13'd5);
    send_pixel(12'd0, 12'd0, 16'd2);
    setup_frame(MODE_RADIAL, 13'd1, 13'd1);
    send_pixel(12'd0, 12'd0, 16'd4);
    send_pixel(12'd1, 12'd0, 16'd4);
    send_pixel(12'd0, 12'd1, 16'd4);
    // ignored register index
    drain();
    write_reg(2'd3, 13'h1ABC);
    send_pixel(12'd0, 12'd0, 16'd5);
  endtask

  // random frames; mostly in-frame coordinates, some beyond the edge
  task automatic test_random(input int count);
    logic [12:0] w, h;
    logic [11:0] px, py;
    int sel;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        sel = $urandom_range(0, 5);
        w = (sel == 0) ? 13'd4096 : (sel == 1) ? 13'($urandom_range(1, 8191))
          : 13'($urandom_range(1, 4096));
        sel = $urandom_range(0, 5);
        h = (sel == 0) ? 13'd4096 : (sel == 1) ? 13'($urandom_range(0, 8191))
          : 13'($urandom_range(1, 4096));
        setup_frame(2'($urandom_range(0, 3)), w, h);
      end
      w = (cur_width > MAX_DIM) ? MAX_DIM : cur_width;
      h = (cur_height > MAX_DIM) ? MAX_DIM : cur_height;
      sel = $urandom_range(0, 9);
      if (sel < 7 && w != 0 && h != 0) begin
        px = 12'($urandom_range(0, w - 1));
        py = 12'($urandom_range(0, h - 1));
      end else if (sel == 7 && w != 0 && h != 0) begin
        px = 12'(w - 1);
        py = 12'(h - 1);
      end else begin
        px = 12'($urandom);
        py = 12'($urandom);
      end
      send_pixel(px, py, 16'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250);
    // sender holds off until every expected pixel is back
    drain();
    test_random(150);
    // final stretch with no idling
    idle_enable = 1'b0;
    test_random(100);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/tpg_pkg.sv
hdl/tpg_root_cell.sv
hdl/tpg_div_cell.sv
hdl/test_pattern_pixel_generator_unit.sv
sim/tb_test_pattern_pixel_generator_unit.sv
